// ===== rtl/pnoa_pkg.sv =====
// Shared types, constants and the multiply microprogram of the polar/nematic
// order accumulator. Used by every module of the block; depends on nothing.
`default_nettype none
package pnoa_pkg;

  localparam int FracBits     = 15;
  localparam int MaxParticles = 65536;
  localparam int CountW       = $clog2(MaxParticles + 1);
  localparam int CompW        = 16;
  localparam int MagW         = 16;
  localparam int SumW         = 32;
  localparam int OpW          = 33;
  localparam int ProdW        = 2 * OpW;
  localparam int VMagW        = 50;
  localparam int NormW        = 31;
  localparam int SqInW        = 64;
  localparam int RootW        = 32;
  localparam int DivNumW      = 48;
  localparam int DivDenW      = 32;
  localparam int CfgAddrW     = 2;
  localparam int StepW        = 5;

  localparam logic [CfgAddrW-1:0] CfgDirX = CfgAddrW'(0);
  localparam logic [CfgAddrW-1:0] CfgDirY = CfgAddrW'(1);
  localparam logic [CfgAddrW-1:0] CfgDirZ = CfgAddrW'(2);

  localparam logic signed [CompW-1:0] DirXReset = CompW'(0);
  localparam logic signed [CompW-1:0] DirYReset = CompW'(0);
  localparam logic signed [CompW-1:0] DirZReset = CompW'(32767);

  // microprogram segments
  localparam logic [StepW-1:0] VFirst   = StepW'(0);
  localparam logic [StepW-1:0] VLast    = StepW'(17);
  localparam logic [StepW-1:0] SqFirst  = StepW'(18);
  localparam logic [StepW-1:0] SqLast   = StepW'(20);
  localparam logic [StepW-1:0] DblFirst = StepW'(21);
  localparam logic [StepW-1:0] DblLast  = StepW'(24);
  localparam logic [StepW-1:0] PolFirst = StepW'(25);
  localparam logic [StepW-1:0] PolLast  = StepW'(27);
  localparam logic [StepW-1:0] NemFirst = StepW'(28);
  localparam logic [StepW-1:0] NemLast  = StepW'(30);

  typedef struct packed {
    logic signed [CompW-1:0] quat_w;
    logic signed [CompW-1:0] quat_x;
    logic signed [CompW-1:0] quat_y;
    logic signed [CompW-1:0] quat_z;
    logic                    last_particle;
  } in_item_t;

  typedef struct packed {
    logic [MagW-1:0]   polar_mag;
    logic [MagW-1:0]   nematic_mag;
    logic [CountW-1:0] particle_count;
  } out_item_t;

  typedef enum logic [4:0] {
    M_NONE, M_WW, M_XX, M_YY, M_ZZ, M_XDX, M_YDY, M_ZDZ, M_YDZ, M_ZDY, M_ZDX, M_XDZ,
    M_NDX, M_DOT2X, M_W2CX, M_NDY, M_DOT2Y, M_W2CY, M_AA, M_BB, M_CC, M_SS, M_CS,
    M_PRR, M_PII, M_NRR, M_NII
  } mul_sel_e;

  typedef enum logic [1:0] {A_HOLD, A_LOAD, A_ADD, A_SUB} acc_op_e;

  typedef enum logic [3:0] {
    D_NONE, D_N, D_DOT, D_CX, D_CY, D_VX, D_VY, D_C2, D_S2
  } dst_e;

  typedef enum logic [1:0] {DV_COS, DV_SIN, DV_MAG} div_sel_e;

  typedef enum logic [2:0] {CAP_NONE, CAP_CM, CAP_SM, CAP_POL, CAP_NEM} cap_e;

  typedef enum logic [4:0] {
    S_IDLE, S_V, S_NORM, S_SQ, S_RGO, S_RWT, S_CGO, S_CWT, S_SGO, S_SWT, S_DBL,
    S_ADD, S_CHK, S_MAG, S_MGO, S_MWT, S_QGO, S_QWT, S_EMIT
  } state_e;

  // acc_op and dst act on the product issued by the previous step
  typedef struct packed {
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    dst_e     dst;
  } uop_t;

  typedef struct packed {
    uop_t     uop;
    logic     load;
    logic     norm_shift;
    logic     sqrt_start;
    logic     div_start;
    div_sel_e div_sel;
    cap_e     cap;
    logic     accum;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic norm_done;
    logic zero;
    logic full;
    logic last;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic uop_t ucode(logic [StepW-1:0] step);
    uop_t u;
    u = '{M_NONE, A_HOLD, D_NONE};
    case (step)
      5'd0:  u = '{M_WW,    A_HOLD, D_NONE};
      5'd1:  u = '{M_XX,    A_LOAD, D_NONE};
      5'd2:  u = '{M_YY,    A_SUB,  D_NONE};
      5'd3:  u = '{M_ZZ,    A_SUB,  D_NONE};
      5'd4:  u = '{M_XDX,   A_SUB,  D_N};
      5'd5:  u = '{M_YDY,   A_LOAD, D_NONE};
      5'd6:  u = '{M_ZDZ,   A_ADD,  D_NONE};
      5'd7:  u = '{M_YDZ,   A_ADD,  D_DOT};
      5'd8:  u = '{M_ZDY,   A_LOAD, D_NONE};
      5'd9:  u = '{M_ZDX,   A_SUB,  D_CX};
      5'd10: u = '{M_XDZ,   A_LOAD, D_NONE};
      5'd11: u = '{M_NDX,   A_SUB,  D_CY};
      5'd12: u = '{M_DOT2X, A_LOAD, D_NONE};
      5'd13: u = '{M_W2CX,  A_ADD,  D_NONE};
      5'd14: u = '{M_NDY,   A_ADD,  D_VX};
      5'd15: u = '{M_DOT2Y, A_LOAD, D_NONE};
      5'd16: u = '{M_W2CY,  A_ADD,  D_NONE};
      5'd17: u = '{M_NONE,  A_ADD,  D_VY};
      5'd18: u = '{M_AA,    A_HOLD, D_NONE};
      5'd19: u = '{M_BB,    A_LOAD, D_NONE};
      5'd20: u = '{M_NONE,  A_ADD,  D_NONE};
      5'd21: u = '{M_CC,    A_HOLD, D_NONE};
      5'd22: u = '{M_SS,    A_LOAD, D_NONE};
      5'd23: u = '{M_CS,    A_SUB,  D_C2};
      5'd24: u = '{M_NONE,  A_LOAD, D_S2};
      5'd25: u = '{M_PRR,   A_HOLD, D_NONE};
      5'd26: u = '{M_PII,   A_LOAD, D_NONE};
      5'd27: u = '{M_NONE,  A_ADD,  D_NONE};
      5'd28: u = '{M_NRR,   A_HOLD, D_NONE};
      5'd29: u = '{M_NII,   A_LOAD, D_NONE};
      5'd30: u = '{M_NONE,  A_ADD,  D_NONE};
      default: u = '{M_NONE, A_HOLD, D_NONE};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/polar_nematic_order_accumulator.sv =====
// Top level of the polar/nematic order accumulator: controller plus datapath.
// Depends on pnoa_pkg, pnoa_ctrl and pnoa_datapath.
//
// One orientation quaternion per item is rotated against the director, its
// in-plane unit phasor and double-angle phasor are added to saturating sums,
// and an item marked last emits the polar and nematic magnitudes with the
// particle count, then clears the sums. Items are handled one at a time: an
// ordinary item runs the 18-step shared multiplier program, up to 19
// normalization shifts, a square root and the two divides of the angle
// normalization; an item whose rotated vector has no in-plane part skips the
// root and divides. A last item adds two more root/divide passes and may wait
// for the previous result to leave. An item arriving once the snapshot holds
// 65536 particles is not counted. A result waits in an output register, and
// the next item is accepted meanwhile.
`default_nettype none
module polar_nematic_order_accumulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pnoa_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pnoa_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pnoa_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [pnoa_pkg::CompW-1:0]    cfg_data_i
);
  import pnoa_pkg::*;

  cmd_t    cmd;
  status_t status;

  pnoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pnoa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );
endmodule
`default_nettype wire

// ===== rtl/pnoa_sqrt.sv =====
// Bit-pair integer square root, one iteration per cycle.
// Depends on pnoa_pkg for widths.
`default_nettype none
module pnoa_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pnoa_pkg::SqInW-1:0] rad_i,
  output logic                       done_o,
  output logic [pnoa_pkg::RootW-1:0] root_o
);
  import pnoa_pkg::*;

  logic [SqInW-1:0] n_q, res_q, bit_q, trial;
  logic             busy_q, done_q;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= rad_i;
      res_q <= '0;
      bit_q <= SqInW'(1) << (SqInW - 2);
    end else if (busy_q) begin
      if (n_q >= trial) begin
        n_q   <= n_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[RootW-1:0];
endmodule
`default_nettype wire

// ===== rtl/pnoa_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pnoa_pkg for widths.
`default_nettype none
module pnoa_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pnoa_pkg::DivNumW-1:0] num_i,
  input  logic [pnoa_pkg::DivDenW-1:0] den_i,
  output logic                         done_o,
  output logic [pnoa_pkg::DivNumW-1:0] quot_o
);
  import pnoa_pkg::*;

  localparam int CntW = $clog2(DivNumW);

  logic [DivNumW-1:0] num_q;
  logic [DivDenW-1:0] den_q, rem_q;
  logic [DivDenW:0]   rem_sh;
  logic               qbit;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q, done_q;

  assign rem_sh = {rem_q, num_q[DivNumW-1]};
  assign qbit   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivNumW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? DivDenW'(rem_sh - {1'b0, den_q}) : rem_sh[DivDenW-1:0];
      num_q <= {num_q[DivNumW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;
endmodule
`default_nettype wire

// ===== rtl/pnoa_datapath.sv =====
// Datapath: config registers, shared multiplier and accumulator, phasor sums,
// result register. Depends on pnoa_pkg, pnoa_sqrt and pnoa_div.
`default_nettype none
module pnoa_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pnoa_pkg::in_item_t            in_data_i,
  input  logic                          cfg_we_i,
  input  logic [pnoa_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [pnoa_pkg::CompW-1:0]    cfg_data_i,
  input  pnoa_pkg::cmd_t                cmd_i,
  output pnoa_pkg::status_t             status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output pnoa_pkg::out_item_t           out_data_o
);
  import pnoa_pkg::*;

  localparam logic [SumW-1:0]    OneW   = SumW'(1) << FracBits;
  localparam logic [SumW-1:0]    HalfW  = OneW >> 1;
  localparam logic [DivNumW-1:0] OneQ   = DivNumW'(1) << FracBits;
  localparam logic [DivNumW-1:0] MagMax = DivNumW'({MagW{1'b1}});
  localparam logic signed [SumW:0] SumMax = {2'b00, {(SumW-1){1'b1}}};
  localparam logic signed [SumW:0] SumMin = {2'b11, {(SumW-1){1'b0}}};

  function automatic logic signed [OpW-1:0] abs_sum(logic signed [SumW-1:0] s);
    logic signed [OpW-1:0] e;
    e = OpW'(s);
    return e[OpW-1] ? -e : e;
  endfunction

  function automatic logic signed [FracBits:0] lim_sign(logic [SumW-1:0] m, logic neg);
    logic [SumW-1:0]        l;
    logic signed [FracBits:0] v;
    l = (m > OneW - SumW'(1)) ? OneW - SumW'(1) : m;
    v = {1'b0, l[FracBits-1:0]};
    return neg ? -v : v;
  endfunction

  function automatic logic signed [SumW-1:0] sat_add(logic signed [SumW-1:0] s,
                                                      logic signed [FracBits:0] p);
    logic signed [SumW:0] t;
    t = (SumW+1)'(s) + (SumW+1)'(p);
    if (t > SumMax) t = SumMax;
    if (t < SumMin) t = SumMin;
    return t[SumW-1:0];
  endfunction

  logic signed [CompW-1:0] dir_x_q, dir_y_q, dir_z_q;
  logic signed [CompW-1:0] w_q, x_q, y_q, z_q;
  logic                    last_q;
  logic signed [OpW-1:0]   op_a, op_b;
  logic signed [ProdW-1:0] p_q, acc_q, acc_d, acc_abs;
  logic signed [OpW-1:0]   n_q, dot_q, cx_q, cy_q;
  logic [VMagW-1:0]        a_q, b_q;
  logic                    vx_neg_q, vy_neg_q;
  logic [FracBits:0]       cm_q, sm_q;
  logic signed [SumW-1:0]  c2_q;
  logic [SumW-1:0]         s2_q;
  logic signed [SumW-1:0]  pol_re_q, pol_im_q, nem_re_q, nem_im_q;
  logic [CountW-1:0]       seen_q, count_den;
  logic [MagW-1:0]         pol_mag_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  logic                    sqrt_done, div_done;
  logic [RootW-1:0]        root;
  logic [DivNumW-1:0]      div_num, quot;
  logic [DivDenW-1:0]      div_den;
  logic [MagW-1:0]         quot_sat;

  logic [SumW-1:0]         c2abs, c2m, s2m;
  logic                    c2neg;
  logic signed [FracBits:0] pc, ps, nc, ns;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_x_q <= DirXReset;
      dir_y_q <= DirYReset;
      dir_z_q <= DirZReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgDirX: dir_x_q <= cfg_data_i;
        CfgDirY: dir_y_q <= cfg_data_i;
        CfgDirZ: dir_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q    <= in_data_i.quat_w;
      x_q    <= in_data_i.quat_x;
      y_q    <= in_data_i.quat_y;
      z_q    <= in_data_i.quat_z;
      last_q <= in_data_i.last_particle;
    end
  end

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.uop.mul_sel)
      M_WW:    begin op_a = OpW'(w_q);   op_b = OpW'(w_q); end
      M_XX:    begin op_a = OpW'(x_q);   op_b = OpW'(x_q); end
      M_YY:    begin op_a = OpW'(y_q);   op_b = OpW'(y_q); end
      M_ZZ:    begin op_a = OpW'(z_q);   op_b = OpW'(z_q); end
      M_XDX:   begin op_a = OpW'(x_q);   op_b = OpW'(dir_x_q); end
      M_YDY:   begin op_a = OpW'(y_q);   op_b = OpW'(dir_y_q); end
      M_ZDZ:   begin op_a = OpW'(z_q);   op_b = OpW'(dir_z_q); end
      M_YDZ:   begin op_a = OpW'(y_q);   op_b = OpW'(dir_z_q); end
      M_ZDY:   begin op_a = OpW'(z_q);   op_b = OpW'(dir_y_q); end
      M_ZDX:   begin op_a = OpW'(z_q);   op_b = OpW'(dir_x_q); end
      M_XDZ:   begin op_a = OpW'(x_q);   op_b = OpW'(dir_z_q); end
      M_NDX:   begin op_a = n_q;         op_b = OpW'(dir_x_q); end
      M_DOT2X: begin op_a = dot_q;       op_b = OpW'(x_q) <<< 1; end
      M_W2CX:  begin op_a = cx_q;        op_b = OpW'(w_q) <<< 1; end
      M_NDY:   begin op_a = n_q;         op_b = OpW'(dir_y_q); end
      M_DOT2Y: begin op_a = dot_q;       op_b = OpW'(y_q) <<< 1; end
      M_W2CY:  begin op_a = cy_q;        op_b = OpW'(w_q) <<< 1; end
      M_AA:    begin op_a = OpW'(a_q[NormW-1:0]); op_b = OpW'(a_q[NormW-1:0]); end
      M_BB:    begin op_a = OpW'(b_q[NormW-1:0]); op_b = OpW'(b_q[NormW-1:0]); end
      M_CC:    begin op_a = OpW'(cm_q);  op_b = OpW'(cm_q); end
      M_SS:    begin op_a = OpW'(sm_q);  op_b = OpW'(sm_q); end
      M_CS:    begin op_a = OpW'(cm_q);  op_b = OpW'(sm_q); end
      M_PRR:   begin op_a = abs_sum(pol_re_q); op_b = abs_sum(pol_re_q); end
      M_PII:   begin op_a = abs_sum(pol_im_q); op_b = abs_sum(pol_im_q); end
      M_NRR:   begin op_a = abs_sum(nem_re_q); op_b = abs_sum(nem_re_q); end
      M_NII:   begin op_a = abs_sum(nem_im_q); op_b = abs_sum(nem_im_q); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    case (cmd_i.uop.acc_op)
      A_LOAD:  acc_d = p_q;
      A_ADD:   acc_d = acc_q + p_q;
      A_SUB:   acc_d = acc_q - p_q;
      default: acc_d = acc_q;
    endcase
    acc_abs = acc_d[ProdW-1] ? -acc_d : acc_d;
  end

  always_ff @(posedge clk_i) begin
    p_q   <= op_a * op_b;
    acc_q <= acc_d;
    case (cmd_i.uop.dst)
      D_N:   n_q   <= acc_d[OpW-1:0];
      D_DOT: dot_q <= acc_d[OpW-1:0];
      D_CX:  cx_q  <= acc_d[OpW-1:0];
      D_CY:  cy_q  <= acc_d[OpW-1:0];
      D_VX: begin
        vx_neg_q <= acc_d[ProdW-1];
        a_q      <= acc_abs[VMagW-1:0];
      end
      D_VY: begin
        vy_neg_q <= acc_d[ProdW-1];
        b_q      <= acc_abs[VMagW-1:0];
      end
      D_C2:  c2_q <= acc_d[SumW-1:0];
      D_S2:  s2_q <= acc_d[SumW-1:0];
      default: ;
    endcase
    if (cmd_i.norm_shift) begin
      a_q <= a_q >> 1;
      b_q <= b_q >> 1;
    end
  end

  // divider operands: rounded cos/sin, or magnitude over count
  assign count_den = (seen_q == '0) ? CountW'(1) : seen_q;
  always_comb begin
    case (cmd_i.div_sel)
      DV_COS: begin
        div_num = (DivNumW'(a_q[NormW-1:0]) << FracBits) + DivNumW'(root[RootW-1:1]);
        div_den = root;
      end
      DV_SIN: begin
        div_num = (DivNumW'(b_q[NormW-1:0]) << FracBits) + DivNumW'(root[RootW-1:1]);
        div_den = root;
      end
      default: begin
        div_num = DivNumW'(root) << 1;
        div_den = DivDenW'(count_den);
      end
    endcase
  end

  pnoa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (acc_q[SqInW-1:0]),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  pnoa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign quot_sat = (quot > MagMax) ? MagMax[MagW-1:0] : quot[MagW-1:0];

  always_ff @(posedge clk_i) begin
    case (cmd_i.cap)
      CAP_CM:  cm_q <= (quot > OneQ) ? OneQ[FracBits:0] : quot[FracBits:0];
      CAP_SM:  sm_q <= (quot > OneQ) ? OneQ[FracBits:0] : quot[FracBits:0];
      CAP_POL: pol_mag_q <= quot_sat;
      default: ;
    endcase
  end

  // phasors of the angle and the double angle
  always_comb begin
    c2neg = c2_q[SumW-1];
    c2abs = c2neg ? SumW'(-c2_q) : SumW'(c2_q);
    c2m   = (c2abs + HalfW) >> FracBits;
    s2m   = ((s2_q << 1) + HalfW) >> FracBits;
    if (status_o.zero) begin
      pc = lim_sign(OneW, 1'b0);
      ps = lim_sign('0, 1'b0);
      nc = lim_sign(OneW, 1'b0);
      ns = lim_sign('0, 1'b0);
    end else begin
      pc = lim_sign(SumW'(cm_q), vx_neg_q);
      ps = lim_sign(SumW'(sm_q), vy_neg_q);
      nc = lim_sign(c2m, c2neg);
      ns = lim_sign(s2m, vx_neg_q ^ vy_neg_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_re_q <= '0;
      pol_im_q <= '0;
      nem_re_q <= '0;
      nem_im_q <= '0;
      seen_q   <= '0;
    end else if (cmd_i.emit) begin
      pol_re_q <= '0;
      pol_im_q <= '0;
      nem_re_q <= '0;
      nem_im_q <= '0;
      seen_q   <= '0;
    end else if (cmd_i.accum) begin
      pol_re_q <= sat_add(pol_re_q, pc);
      pol_im_q <= sat_add(pol_im_q, ps);
      nem_re_q <= sat_add(nem_re_q, nc);
      nem_im_q <= sat_add(nem_im_q, ns);
      seen_q   <= seen_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.polar_mag      <= pol_mag_q;
      out_q.nematic_mag    <= quot_sat;
      out_q.particle_count <= seen_q;
    end
  end

  assign status_o.norm_done = (a_q[VMagW-1:NormW] == '0) && (b_q[VMagW-1:NormW] == '0);
  assign status_o.zero      = (a_q == '0) && (b_q == '0);
  assign status_o.full      = seen_q == CountW'(MaxParticles);
  assign status_o.last      = last_q;
  assign status_o.sqrt_done = sqrt_done;
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

// ===== rtl/pnoa_ctrl.sv =====
// Controller: sequences the multiply microprogram, the root and divide units,
// accumulation and result hand-off. Depends on pnoa_pkg.
`default_nettype none
module pnoa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pnoa_pkg::status_t status_i,
  output pnoa_pkg::cmd_t    cmd_o
);
  import pnoa_pkg::*;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             pass_q, pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    pass_d  = pass_q;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        state_d = status_i.full ? S_CHK : S_V;
        step_d  = VFirst;
      end
      S_V: begin
        step_d = step_q + StepW'(1);
        if (step_q == VLast) state_d = S_NORM;
      end
      S_NORM: if (status_i.norm_done) begin
        state_d = status_i.zero ? S_ADD : S_SQ;
        step_d  = SqFirst;
      end
      S_SQ: begin
        step_d = step_q + StepW'(1);
        if (step_q == SqLast) state_d = S_RGO;
      end
      S_RGO: state_d = S_RWT;
      S_RWT: if (status_i.sqrt_done) state_d = S_CGO;
      S_CGO: state_d = S_CWT;
      S_CWT: if (status_i.div_done) state_d = S_SGO;
      S_SGO: state_d = S_SWT;
      S_SWT: if (status_i.div_done) begin
        state_d = S_DBL;
        step_d  = DblFirst;
      end
      S_DBL: begin
        step_d = step_q + StepW'(1);
        if (step_q == DblLast) state_d = S_ADD;
      end
      S_ADD: state_d = S_CHK;
      S_CHK: if (status_i.last) begin
        state_d = S_MAG;
        step_d  = PolFirst;
        pass_d  = 1'b0;
      end else begin
        state_d = S_IDLE;
      end
      S_MAG: begin
        step_d = step_q + StepW'(1);
        if (step_q == (pass_q ? NemLast : PolLast)) state_d = S_MGO;
      end
      S_MGO: state_d = S_MWT;
      S_MWT: if (status_i.sqrt_done) state_d = S_QGO;
      S_QGO: state_d = S_QWT;
      S_QWT: if (status_i.div_done) begin
        if (pass_q) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_MAG;
          step_d  = NemFirst;
          pass_d  = 1'b1;
        end
      end
      S_EMIT: if (status_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.uop     = '{M_NONE, A_HOLD, D_NONE};
    cmd_o.div_sel = DV_MAG;
    cmd_o.cap     = CAP_NONE;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_V, S_SQ, S_DBL, S_MAG: cmd_o.uop = ucode(step_q);
      S_NORM: cmd_o.norm_shift = !status_i.norm_done;
      S_RGO, S_MGO: cmd_o.sqrt_start = 1'b1;
      S_CGO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DV_COS;
      end
      S_CWT: if (status_i.div_done) cmd_o.cap = CAP_CM;
      S_SGO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DV_SIN;
      end
      S_SWT: if (status_i.div_done) cmd_o.cap = CAP_SM;
      S_ADD: cmd_o.accum = 1'b1;
      S_QGO: cmd_o.div_start = 1'b1;
      S_QWT: if (status_i.div_done && !pass_q) cmd_o.cap = CAP_POL;
      S_EMIT: cmd_o.emit = status_i.out_free;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/pnoa_checker.sv =====
// Port-level checks for the order accumulator, bound to the top level.
// Depends on pnoa_pkg and polar_nematic_order_accumulator.
`default_nettype none
module pnoa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input pnoa_pkg::out_item_t out_data_o
);
  import pnoa_pkg::*;

  // a result always averages at least one particle
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.particle_count != '0)
    else $error("result with zero particle count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // the block is not ready again in the cycle after it accepts an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accepting an item");

  // a result never appears the cycle right after an item is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("result too soon after item");
endmodule

bind polar_nematic_order_accumulator pnoa_checker u_pnoa_checker (.*);
`default_nettype wire

// ===== dv/tb_polar_nematic_order_accumulator.sv =====
// Testbench for polar_nematic_order_accumulator: randomized snapshots of particle
// quaternions are driven and the emitted order magnitudes are checked against an
// internal predictor. Depends on pnoa_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_polar_nematic_order_accumulator;
  import pnoa_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 400;

  logic                clk_i, rst_ni;
  logic                in_valid_i, in_ready_o;
  in_item_t            in_data_i;
  logic                out_valid_o, out_ready_i;
  out_item_t           out_data_o;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CompW-1:0]    cfg_data_i;

  polar_nematic_order_accumulator uut (.*);

  // predictor state
  longint dir_x, dir_y, dir_z;
  longint pol_re, pol_im, nem_re, nem_im;
  longint n_seen;

  in_item_t  pending_items[$];
  out_item_t expected_orders[$];
  int        mismatches;
  int        idle_cycles;
  bit        timed_out;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint root64(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip_comp(longint v);
    longint m;
    m = (64'sd1 << FracBits) - 1;
    return v > m ? m : (v < -m ? -m : v);
  endfunction

  function automatic longint sum_sat(longint s, longint p);
    longint t;
    t = s + p;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t;
  endfunction

  function automatic logic [MagW-1:0] order_mag(longint re, longint im, longint cnt);
    longint unsigned a, b, m;
    a = re < 0 ? -re : re;
    b = im < 0 ? -im : im;
    m = (root64(a * a + b * b) << 16) / (cnt << FracBits);
    return m > 65535 ? 16'hFFFF : m[15:0];
  endfunction

  function automatic void queue_item(input in_item_t it);
    pending_items = {pending_items, it};
  endfunction

  task automatic predict_particle(input in_item_t it);
    longint w, x, y, z, n, dt, vx, vy, pc, ps, nc, ns, one;
    longint unsigned a, b, r, cm, sm, c2m, s2m;
    bit c2neg;
    out_item_t res;
    if (n_seen < MaxParticles) begin
      w = it.quat_w; x = it.quat_x; y = it.quat_y; z = it.quat_z;
      one = 64'sd1 << FracBits;
      n = w * w - x * x - y * y - z * z;
      dt = x * dir_x + y * dir_y + z * dir_z;
      vx = n * dir_x + 2 * dt * x + 2 * w * (y * dir_z - z * dir_y);
      vy = n * dir_y + 2 * dt * y + 2 * w * (z * dir_x - x * dir_z);
      a = vx < 0 ? -vx : vx;
      b = vy < 0 ? -vy : vy;
      while (((a | b) >> 31) != 0) begin
        a >>= 1;
        b >>= 1;
      end
      if (a == 0 && b == 0) begin
        pc = one; ps = 0; nc = one; ns = 0;
      end else begin
        r = root64(a * a + b * b);
        cm = ((a << FracBits) + (r >> 1)) / r;
        sm = ((b << FracBits) + (r >> 1)) / r;
        if (cm > one) cm = one;
        if (sm > one) sm = one;
        pc = vx < 0 ? -longint'(cm) : longint'(cm);
        ps = vy < 0 ? -longint'(sm) : longint'(sm);
        c2neg = sm * sm > cm * cm;
        c2m = c2neg ? sm * sm - cm * cm : cm * cm - sm * sm;
        c2m = (c2m + (one >> 1)) >> FracBits;
        s2m = (2 * cm * sm + (one >> 1)) >> FracBits;
        nc = c2neg ? -longint'(c2m) : longint'(c2m);
        ns = ((vx < 0) != (vy < 0)) ? -longint'(s2m) : longint'(s2m);
      end
      pol_re = sum_sat(pol_re, clip_comp(pc));
      pol_im = sum_sat(pol_im, clip_comp(ps));
      nem_re = sum_sat(nem_re, clip_comp(nc));
      nem_im = sum_sat(nem_im, clip_comp(ns));
      n_seen++;
    end
    if (it.last_particle) begin
      res.polar_mag = order_mag(pol_re, pol_im, n_seen == 0 ? 1 : n_seen);
      res.nematic_mag = order_mag(nem_re, nem_im, n_seen == 0 ? 1 : n_seen);
      res.particle_count = n_seen[CountW-1:0];
      expected_orders = {expected_orders, res};
      pol_re = 0; pol_im = 0; nem_re = 0; nem_im = 0; n_seen = 0;
    end
  endtask

  // accept bookkeeping at the rising edge; drive decisions at the falling edge
  bit in_taken;
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) predict_particle(in_data_i);
  end

  // driver
  int in_wait;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken || !in_valid_i) begin
        if (pending_items.size() != 0 && in_wait == 0) begin
          in_data_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          in_wait    <= $urandom_range(0, 6) * ($urandom_range(0, 3) != 0);
        end else begin
          in_valid_i <= 1'b0;
          if (in_wait != 0) in_wait <= in_wait - 1;
        end
      end
    end
  end

  // monitor
  int out_wait;
  int out_draw;
  bit out_taken;
  always @(posedge clk_i) begin
    out_taken <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_orders.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", out_data_o);
      end else begin
        out_item_t exp_r;
        exp_r = expected_orders.pop_front();
        if (exp_r.polar_mag !== out_data_o.polar_mag ||
            exp_r.nematic_mag !== out_data_o.nematic_mag ||
            exp_r.particle_count !== out_data_o.particle_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: polar exp %0d got %0d, nematic exp %0d got %0d, count exp %0d got %0d",
                     exp_r.polar_mag, out_data_o.polar_mag, exp_r.nematic_mag,
                     out_data_o.nematic_mag, exp_r.particle_count, out_data_o.particle_count);
        end
      end
    end
  end

  // each result item is held off for a freshly drawn number of cycles
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        out_draw = $urandom_range(0, 6);
        out_wait    <= out_draw;
        out_ready_i <= (out_draw == 0);
      end else if (out_valid_o && !out_ready_i) begin
        if (out_wait == 0) out_ready_i <= 1'b1;
        else out_wait <= out_wait - 1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_dir(input logic [CfgAddrW-1:0] idx, input logic [CompW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgDirX) dir_x = longint'($signed(val));
    else if (idx == CfgDirY) dir_y = longint'($signed(val));
    else if (idx == CfgDirZ) dir_z = longint'($signed(val));
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid_i || expected_orders.size() != 0)
      @(posedge clk_i);
    // a non-last item may still be in flight
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic in_item_t make_quat(logic [15:0] w, logic [15:0] x,
                                         logic [15:0] y, logic [15:0] z, bit lst);
    in_item_t it;
    it.quat_w = w; it.quat_x = x; it.quat_y = y; it.quat_z = z;
    it.last_particle = lst;
    return it;
  endfunction

  function automatic logic [15:0] rnd_comp();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_snapshots(input int n_items);
    int left, sz;
    left = n_items;
    while (left > 0) begin
      sz = $urandom_range(1, 12);
      if (sz > left) sz = left;
      for (int i = 0; i < sz; i++) begin
        if ($urandom_range(0, 3) == 0)
          queue_item(make_quat(16'h7FFF, 0, 0, rnd_comp(), i == sz - 1));
        else
          queue_item(make_quat(rnd_comp(), rnd_comp(), rnd_comp(),
                               rnd_comp(), i == sz - 1));
      end
      left -= sz;
    end
  endtask

  initial begin
    logic [15:0] dirs[4][3];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_data_i = '0;
    in_wait = 0; out_wait = 0; out_draw = 0; in_taken = 1'b0; out_taken = 1'b0;
    idle_cycles = 0; mismatches = 0; timed_out = 1'b0;
    dir_x = DirXReset; dir_y = DirYReset; dir_z = DirZReset;
    pol_re = 0; pol_im = 0; nem_re = 0; nem_im = 0; n_seen = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset director, extremes, zero quaternion, lone last item
    queue_item(make_quat(16'h7FFF, 0, 0, 0, 1'b1));
    queue_item(make_quat(0, 0, 0, 0, 1'b1));
    queue_item(make_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    queue_item(make_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
    queue_item(make_quat(16'h5A82, 16'h5A82, 0, 0, 1'b0));
    queue_item(make_quat(16'h5A82, 0, 16'h5A82, 0, 1'b0));
    queue_item(make_quat(16'h5A82, 0, 16'hA57E, 0, 1'b1));
    queue_item(make_quat(16'h5A82, 16'h5A82, 0, 0, 1'b0));
    queue_item(make_quat(16'h5A82, 16'h5A82, 0, 0, 1'b1));
    wait_idle();
    write_dir(CfgDirX, 16'h7FFF);
    write_dir(CfgDirY, 16'h0000);
    write_dir(CfgDirZ, 16'h0000);
    write_dir(2'd3, 16'h1234); // unused index, ignored
    queue_item(make_quat(16'h7FFF, 0, 0, 0, 1'b0));
    queue_item(make_quat(0, 0, 0, 16'h7FFF, 1'b0));
    queue_item(make_quat(16'h5A82, 0, 0, 16'h5A82, 1'b0));
    queue_item(make_quat(16'h5A82, 0, 0, 16'hA57E, 1'b1));
    queue_item(make_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1));
    wait_idle();

    dirs[0] = '{16'h8000, 16'h8000, 16'h8000};
    dirs[1] = '{16'h7FFF, 16'h7FFF, 16'h7FFF};
    dirs[2] = '{16'h0000, 16'h0000, 16'h0000};
    dirs[3] = '{16'h4000, 16'hC000, 16'h2000};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 4) begin
        write_dir(CfgDirX, dirs[ph][0]);
        write_dir(CfgDirY, dirs[ph][1]);
        write_dir(CfgDirZ, dirs[ph][2]);
      end else begin
        write_dir(CfgDirX, 16'($urandom));
        write_dir(CfgDirY, 16'($urandom));
        write_dir(CfgDirZ, 16'($urandom));
      end
      queue_snapshots(48);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/pnoa_pkg.sv
rtl/pnoa_sqrt.sv
rtl/pnoa_div.sv
rtl/pnoa_datapath.sv
rtl/pnoa_ctrl.sv
rtl/polar_nematic_order_accumulator.sv
rtl/pnoa_checker.sv
dv/tb_polar_nematic_order_accumulator.sv
